@@ sv/md4sh_pkg.sv @@
package md4sh_pkg;

  // Initial chaining words
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hEFCDAB89;
  localparam logic [31:0] IV_C = 32'h98BADCFE;
  localparam logic [31:0] IV_D = 32'h10325476;

  // Round constants for the second and third passes
  localparam logic [31:0] K_PASS2 = 32'h5A827999;
  localparam logic [31:0] K_PASS3 = 32'h6ED9EBA1;

  // Pad marker byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned WORDS_PER_BLOCK = 16;
  localparam int unsigned ROUNDS          = 48;

  // Round pass codes
  localparam logic [1:0] PASS_F = 2'd0;
  localparam logic [1:0] PASS_G = 2'd1;
  localparam logic [1:0] PASS_H = 2'd2;

  // Buffer word used by a round: in order, then column order, then bit-reversed
  function automatic logic [3:0] word_index(input logic [5:0] rnd);
    logic [3:0] idx;
    case (rnd[5:4])
      PASS_F:  idx = rnd[3:0];
      PASS_G:  idx = {rnd[1:0], rnd[3:2]};
      PASS_H:  idx = {rnd[0], rnd[1], rnd[2], rnd[3]};
      default: idx = rnd[3:0];
    endcase
    return idx;
  endfunction

  // Rotate amount of a round
  function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
    logic [4:0] s;
    case ({rnd[5:4], rnd[1:0]})
      4'b00_00: s = 5'd3;
      4'b00_01: s = 5'd7;
      4'b00_10: s = 5'd11;
      4'b00_11: s = 5'd19;
      4'b01_00: s = 5'd3;
      4'b01_01: s = 5'd5;
      4'b01_10: s = 5'd9;
      4'b01_11: s = 5'd13;
      4'b10_00: s = 5'd3;
      4'b10_01: s = 5'd9;
      4'b10_10: s = 5'd11;
      4'b10_11: s = 5'd15;
      default:  s = 5'd3;
    endcase
    return s;
  endfunction

  // 32-bit rotate left
  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {v, v} << s;
    return dbl[63:32];
  endfunction

endpackage

@@ sv/md4_stream_hasher_top.sv @@
// MD4 hasher for a message delivered as 32-bit words, first byte in bits 7:0.
// Message words are taken one per cycle while the hasher is idle, into a 16-word
// block buffer. When a block fills, the block stalls its input for 48 rounds on
// one shared round unit (one round per cycle) and the fold of the result into
// the chaining value; no new word is taken until that block is through. On the
// final word the padding, zero fill and 64-bit bit length are written into the
// buffer one word per cycle, which needs one or two further compressions; the
// digest then loads into the output register, and the chaining state, word
// position and length return to their initial values. A digest waiting on the
// output does not hold off new words; only the next digest waits for it to be
// taken.
module md4_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_message_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_final_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high
);
  import md4sh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  state_t      state_r;
  logic [3:0]  pos_r;
  logic [60:0] bytes_r;
  logic [5:0]  round_r;
  logic        padding_r;
  logic        pend80_r;
  logic        len_blk_r;
  logic        out_valid_r;
  logic [31:0] cv_a_r, cv_b_r, cv_c_r, cv_d_r;
  logic [31:0] ra_r, rb_r, rc_r, rd_r;
  logic [31:0] buf_r [WORDS_PER_BLOCK];
  logic [63:0] dig_low_r, dig_high_r;

  logic        acc;
  logic [2:0]  n_clip;
  logic        short_final;
  logic [31:0] final_data;
  logic [31:0] pad_data;
  logic        wr_en;
  logic [31:0] wr_data;
  logic        emit_go;
  logic [63:0] bit_len;
  logic [31:0] fx, kx, xw, sum, rnd_out;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_digest_low  = dig_low_r;
  assign out_digest_high = dig_high_r;

  assign acc     = in_valid && (state_r == S_IDLE);
  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign bit_len = {bytes_r, 3'b000};

  // Final word: clip the count and place the pad marker after the last byte when it fits in the word
  always_comb begin
    n_clip      = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    short_final = in_final_word && (n_clip != 3'd4);
    case (n_clip)
      3'd0:    final_data = {24'h0, PAD_BYTE};
      3'd1:    final_data = {16'h0, PAD_BYTE, in_message_word[7:0]};
      3'd2:    final_data = {8'h0, PAD_BYTE, in_message_word[15:0]};
      3'd3:    final_data = {PAD_BYTE, in_message_word[23:0]};
      default: final_data = in_message_word;
    endcase
  end

  // Pad sequence word: marker, zeros, then length in the last two slots
  always_comb begin
    if (pend80_r) begin
      pad_data = {24'h0, PAD_BYTE};
    end else if (len_blk_r && pos_r == 4'd14) begin
      pad_data = bit_len[31:0];
    end else if (len_blk_r && pos_r == 4'd15) begin
      pad_data = bit_len[63:32];
    end else begin
      pad_data = 32'h0;
    end
  end

  assign wr_en   = acc || (state_r == S_PAD);
  assign wr_data = acc ? (short_final ? final_data : in_message_word) : pad_data;

  // Shared round unit
  always_comb begin
    case (round_r[5:4])
      PASS_F: begin
        fx = (rb_r & rc_r) | (~rb_r & rd_r);
        kx = 32'h0;
      end
      PASS_G: begin
        fx = (rb_r & rc_r) | (rb_r & rd_r) | (rc_r & rd_r);
        kx = K_PASS2;
      end
      default: begin
        fx = rb_r ^ rc_r ^ rd_r;
        kx = K_PASS3;
      end
    endcase
    xw      = buf_r[word_index(round_r)];
    sum     = ra_r + fx + xw + kx;
    rnd_out = rotl32(sum, rot_amount(round_r));
  end

  // Block buffer and digest register
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_r[pos_r] <= wr_data;
    end
    if (emit_go) begin
      dig_low_r  <= {cv_b_r, cv_a_r};
      dig_high_r <= {cv_d_r, cv_c_r};
    end
  end

  // Sequencer, working registers and chaining value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= 4'd0;
      bytes_r     <= 61'd0;
      round_r     <= 6'd0;
      padding_r   <= 1'b0;
      pend80_r    <= 1'b0;
      len_blk_r   <= 1'b0;
      out_valid_r <= 1'b0;
      cv_a_r      <= IV_A;
      cv_b_r      <= IV_B;
      cv_c_r      <= IV_C;
      cv_d_r      <= IV_D;
      ra_r        <= 32'h0;
      rb_r        <= 32'h0;
      rc_r        <= 32'h0;
      rd_r        <= 32'h0;
    end else begin
      // output valid: set on a new digest, cleared when taken
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            pos_r <= pos_r + 4'd1;
            if (!in_final_word) begin
              bytes_r <= bytes_r + 61'd4;
            end else begin
              bytes_r   <= bytes_r + {58'd0, n_clip};
              padding_r <= 1'b1;
              pend80_r  <= !short_final;
              if (short_final) begin
                len_blk_r <= (pos_r <= 4'd13);
              end
            end
            if (pos_r == 4'd15) begin
              state_r <= S_ROUND;
              round_r <= 6'd0;
              ra_r    <= cv_a_r;
              rb_r    <= cv_b_r;
              rc_r    <= cv_c_r;
              rd_r    <= cv_d_r;
            end else if (in_final_word) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pos_r <= pos_r + 4'd1;
          if (pend80_r) begin
            pend80_r  <= 1'b0;
            len_blk_r <= (pos_r <= 4'd13);
          end
          if (pos_r == 4'd15) begin
            state_r <= S_ROUND;
            round_r <= 6'd0;
            ra_r    <= cv_a_r;
            rb_r    <= cv_b_r;
            rc_r    <= cv_c_r;
            rd_r    <= cv_d_r;
          end
        end
        S_ROUND: begin
          // roles rotate: next a is d, next b is the new value
          ra_r    <= rd_r;
          rb_r    <= rnd_out;
          rc_r    <= rb_r;
          rd_r    <= rc_r;
          round_r <= round_r + 6'd1;
          if (round_r == 6'(ROUNDS - 1)) begin
            state_r <= S_FOLD;
          end
        end
        S_FOLD: begin
          cv_a_r <= cv_a_r + ra_r;
          cv_b_r <= cv_b_r + rb_r;
          cv_c_r <= cv_c_r + rc_r;
          cv_d_r <= cv_d_r + rd_r;
          if (padding_r && len_blk_r) begin
            state_r <= S_EMIT;
          end else if (padding_r) begin
            len_blk_r <= 1'b1;
            state_r   <= S_PAD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            cv_a_r      <= IV_A;
            cv_b_r      <= IV_B;
            cv_c_r      <= IV_C;
            cv_d_r      <= IV_D;
            pos_r       <= 4'd0;
            bytes_r     <= 61'd0;
            padding_r   <= 1'b0;
            pend80_r    <= 1'b0;
            len_blk_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
